// ----- rtl/core/mtf_pkg.sv -----
package mtf_pkg;

  localparam int ItemW       = 6;
  localparam int PosW        = 6;
  localparam int OutW        = 7;
  localparam int CountW      = 7;
  localparam int ItemSpan    = 64;
  localparam int DefMaxItems = 64;

  localparam logic [CountW-1:0] CountReset = 7'd64;

  localparam logic ActAccess = 1'b0;
  localparam logic ActReport = 1'b1;

  typedef struct packed {
    logic             action;
    logic [ItemW-1:0] item;
  } mtf_in_t;

  typedef struct packed {
    logic [OutW-1:0] position;
    logic [OutW-1:0] min_position;
    logic [OutW-1:0] max_position;
    logic            bad_item;
  } mtf_out_t;

  // One list slot: the item it holds and that item's position extremes.
  typedef struct packed {
    logic [ItemW-1:0] item;
    logic [PosW-1:0]  least;
    logic [PosW-1:0]  greatest;
  } mtf_rec_t;

  typedef struct packed {
    logic             shift;
    logic [PosW-1:0]  pos;
    logic [ItemW-1:0] item;
  } mtf_ctrl_t;

endpackage

// ----- rtl/core/mtf_cell.sv -----
module mtf_cell #(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mtf_pkg::mtf_ctrl_t ctrl,
  input  mtf_pkg::mtf_rec_t  prev_rec,
  output mtf_pkg::mtf_rec_t  rec,
  output logic              match
);
  import mtf_pkg::*;

  localparam logic [PosW-1:0] IdxV = PosW'(INDEX);

  mtf_rec_t rec_r;
  mtf_rec_t rec_nxt;

  always_comb begin
    rec_nxt = rec_r;
    // Slots from the front up to the hit slot take their neighbor's record.
    if (ctrl.shift && (IdxV <= ctrl.pos)) begin
      rec_nxt = prev_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '{item: IdxV, least: IdxV, greatest: IdxV};
    end else begin
      rec_r <= rec_nxt;
    end
  end

  assign rec   = rec_r;
  assign match = (rec_r.item == ctrl.item);

endmodule

// ----- rtl/core/mtf_gather.sv -----
module mtf_gather #(
  parameter int CELLS = mtf_pkg::DefMaxItems
) (
  input  logic [CELLS-1:0]  match,
  input  mtf_pkg::mtf_rec_t recs [CELLS],
  output logic [mtf_pkg::PosW-1:0] pos,
  output mtf_pkg::mtf_rec_t hit_rec
);
  import mtf_pkg::*;

  // At most one slot matches, so an OR over the masked slots selects it.
  always_comb begin
    pos     = '0;
    hit_rec = '0;
    for (int p = 0; p < CELLS; p++) begin
      if (match[p]) begin
        pos     = pos | PosW'(p);
        hit_rec = hit_rec | recs[p];
      end
    end
  end

endmodule

// ----- rtl/core/move_to_front_position_tracker_core.sv -----
// Each request is accepted in the idle state, passes a lookup state in which every list cell
// compares its item and the hit is encoded, then a move state in which an access that is not
// refused shifts the chain; the result and its strobe are registered as the move state ends.
// busy is high from acceptance until the move state ends, so no new request is taken meanwhile.
// The result is shown for one cycle and cannot be stalled by the receiver.
// Reset (synchronous): list in identity order, extremes of item k both k, count 64.
module move_to_front_position_tracker_core #(
  parameter int MAX_ITEMS = mtf_pkg::DefMaxItems
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  mtf_pkg::mtf_in_t                in_data,
  output logic                            out_valid,
  output mtf_pkg::mtf_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mtf_pkg::CountW-1:0]      cfg_data
);
  import mtf_pkg::*;

  // Only the first ItemSpan items can ever be named, and they never leave
  // the first ItemSpan slots, so the list needs no more cells than that.
  localparam int Cells = (MAX_ITEMS < ItemSpan) ? MAX_ITEMS : ItemSpan;
  localparam logic [CountW-1:0] CellsV = CountW'(Cells);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_MOVE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CountW-1:0] count_r;
  logic              act_r;
  logic [ItemW-1:0]  item_r;
  logic              bad_r;
  logic [PosW-1:0]   pos_r;
  logic [PosW-1:0]   lo_r;
  logic [PosW-1:0]   hi_r;
  logic              out_valid_r;
  mtf_out_t          out_r;

  logic              accept;
  logic              in_bad;
  mtf_ctrl_t         ctrl;
  mtf_rec_t          head;
  logic [Cells-1:0]  match;
  mtf_rec_t          recs [Cells];
  logic [PosW-1:0]   hit_pos;
  mtf_rec_t          hit_rec;
  logic [PosW-1:0]   hit_hi;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_bad    = ({1'b0, in_data.item} >= count_r) || ({1'b0, in_data.item} >= CellsV);

  assign ctrl.shift = (state_r == ST_MOVE) && (act_r == ActAccess) && !bad_r;
  assign ctrl.pos   = pos_r;
  assign ctrl.item  = item_r;
  assign head       = '{item: item_r, least: '0, greatest: hi_r};

  for (genvar g = 0; g < Cells; g++) begin : g_cell
    mtf_rec_t prev;
    if (g == 0) begin : g_head
      assign prev = head;
    end else begin : g_link
      assign prev = recs[g-1];
    end
    mtf_cell #(.INDEX(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .prev_rec (prev),
      .rec      (recs[g]),
      .match    (match[g])
    );
  end

  mtf_gather #(.CELLS(Cells)) u_gather (
    .match   (match),
    .recs    (recs),
    .pos     (hit_pos),
    .hit_rec (hit_rec)
  );

  assign hit_hi = (hit_pos > hit_rec.greatest) ? hit_pos : hit_rec.greatest;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_LOOK;
      ST_LOOK: state_nxt = ST_MOVE;
      ST_MOVE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= CountReset;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_MOVE);
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_data.action;
      item_r <= in_data.item;
      bad_r  <= in_bad;
    end
    if (state_r == ST_LOOK) begin
      pos_r <= hit_pos;
      lo_r  <= hit_rec.least;
      hi_r  <= hit_hi;
    end
    if (state_r == ST_MOVE) begin
      if (bad_r) begin
        out_r <= '{position: '0, min_position: '0, max_position: '0, bad_item: 1'b1};
      end else begin
        out_r.position     <= {1'b0, pos_r} + 7'd1;
        out_r.min_position <= (act_r == ActAccess) ? 7'd1 : ({1'b0, lo_r} + 7'd1);
        out_r.max_position <= {1'b0, hi_r} + 7'd1;
        out_r.bad_item     <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/mtf_checker.sv -----
module mtf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input mtf_pkg::mtf_out_t          out_data
);
  import mtf_pkg::*;

  // Every accepted request must be followed by its result strobe.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result strobe missing after request");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bad_item) |->
      (out_data.position == '0 && out_data.min_position == '0 &&
       out_data.max_position == '0))
    else $error("refused request reports positions");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.bad_item) |->
      (out_data.min_position != '0 && out_data.min_position <= out_data.position &&
       out_data.max_position >= out_data.position))
    else $error("position extremes out of order");

endmodule

bind move_to_front_position_tracker_core mtf_checker u_mtf_checker (.*);

// ----- tb/mtf_position_checker.sv -----
module mtf_position_checker
  import mtf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  mtf_in_t           in_data,
  input  logic              out_valid,
  input  mtf_out_t          out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CountW-1:0] cfg_data,
  output int                mismatches,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ListLen = DefMaxItems;

  // Slot k of the list holds slot_item[k]; extremes are kept per item, 0-based.
  logic [ItemW-1:0]  slot_item [ListLen];
  logic [PosW-1:0]   low_mark  [ListLen];
  logic [PosW-1:0]   high_mark [ListLen];
  logic [CountW-1:0] item_limit;
  mtf_out_t          awaited_extremes [$];
  int                errors = 0;

  task automatic restore_identity();
    for (int k = 0; k < ListLen; k++) begin
      slot_item[k] = ItemW'(k);
      low_mark[k]  = PosW'(k);
      high_mark[k] = PosW'(k);
    end
    item_limit = CountReset;
    awaited_extremes.delete();
  endtask

  function automatic mtf_out_t move_and_report(input mtf_in_t req);
    int       eff;
    int       pos;
    int       hi;
    int       lo;
    mtf_out_t res;
    eff = (int'(item_limit) > ListLen) ? ListLen : int'(item_limit);
    res = '0;
    if (int'(req.item) >= eff) begin
      res.bad_item = 1'b1;
      return res;
    end
    pos = 0;
    for (int k = 0; k < ListLen; k++) begin
      if (slot_item[k] == req.item) pos = k;
    end
    hi = int'(high_mark[req.item]);
    if (pos > hi) hi = pos;
    if (req.action == ActAccess) begin
      for (int k = pos; k > 0; k--) slot_item[k] = slot_item[k-1];
      slot_item[0] = req.item;
      low_mark[req.item]  = '0;
      high_mark[req.item] = PosW'(hi);
      lo = 0;
    end else begin
      lo = int'(low_mark[req.item]);
    end
    res.position     = OutW'(pos + 1);
    res.min_position = OutW'(lo + 1);
    res.max_position = OutW'(hi + 1);
    return res;
  endfunction

  always @(posedge clk) begin
    mtf_out_t want;
    if (!rst_n) begin
      restore_identity();
    end else begin
      // The result leaving at this edge belongs to an older request, so it is
      // matched before a request accepted at the same edge is queued.
      if (out_valid) begin
        if (awaited_extremes.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("Unexpected result with no request outstanding: %p", out_data);
        end else begin
          want = awaited_extremes.pop_front();
          if (out_data.position !== want.position ||
              out_data.min_position !== want.min_position ||
              out_data.max_position !== want.max_position ||
              out_data.bad_item !== want.bad_item) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch: expected pos/min/max/bad %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                       want.position, want.min_position, want.max_position, want.bad_item,
                       out_data.position, out_data.min_position, out_data.max_position,
                       out_data.bad_item);
          end
        end
      end
      if (start && !busy)
        awaited_extremes = {awaited_extremes, move_and_report(in_data)};
      if (cfg_valid && cfg_ready) item_limit = cfg_data;
    end
    mismatches <= errors;
    pending    <= awaited_extremes.size();
  end

endmodule

// ----- tb/tb_move_to_front_position_tracker_core.sv -----
module tb_move_to_front_position_tracker_core;
  import mtf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  mtf_in_t           in_data;
  logic              out_valid;
  mtf_out_t          out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CountW-1:0] cfg_data;
  int                mismatches;
  int                pending;
  int                cycles = 0;
  int                n_access = 0;
  int                n_report = 0;
  int                idle_pct;
  logic [CountW-1:0] cur_count;
  logic [CountW-1:0] phase_counts [8] = '{7'd64, 7'd127, 7'd33, 7'd1, 7'd0, 7'd65, 7'd7,
                                          7'd64};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  move_to_front_position_tracker_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  mtf_position_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Almost half the picks come from the eight lowest items, so that accesses keep reshuffling
  // the same few entries; a tenth of the picks may be out of range.
  function automatic logic [ItemW-1:0] pick_item();
    int eff;
    int r;
    eff = (int'(cur_count) > ItemSpan) ? ItemSpan : int'(cur_count);
    r = $urandom_range(99);
    if (eff == 0 || r < 10) return ItemW'($urandom_range(ItemSpan - 1));
    if (r < 55) return ItemW'($urandom_range(((eff < 8) ? eff : 8) - 1));
    return ItemW'($urandom_range(eff - 1));
  endfunction

  task automatic send(input logic act, input logic [ItemW-1:0] it);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= '{action: act, item: it};
    do @(posedge clk); while (busy);
    if (act == ActAccess) n_access++;
    else n_report++;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_count(input logic [CountW-1:0] v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_count = v;
  endtask

  initial begin
    int n;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = CountReset;
    cur_count = CountReset;
    idle_pct  = 36;
    rst_n     = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: list ends, repeated access of the front, refused items under
    // small counts and a zero count, and accesses under an oversized count.
    send(ActReport, 6'd0);
    send(ActReport, 6'd63);
    send(ActAccess, 6'd63);
    send(ActAccess, 6'd63);
    send(ActAccess, 6'd0);
    send(ActReport, 6'd63);
    send(ActReport, 6'd0);
    send(ActAccess, 6'd42);
    send(ActReport, 6'd42);
    send(ActAccess, 6'd21);
    send(ActReport, 6'd42);
    write_count(7'd10);
    send(ActAccess, 6'd10);
    send(ActReport, 6'd63);
    send(ActAccess, 6'd9);
    send(ActReport, 6'd9);
    write_count(7'd0);
    send(ActAccess, 6'd0);
    send(ActReport, 6'd0);
    write_count(7'd1);
    send(ActAccess, 6'd0);
    send(ActReport, 6'd0);
    send(ActAccess, 6'd1);
    write_count(7'd127);
    send(ActAccess, 6'd63);
    send(ActReport, 6'd21);

    for (int p = 0; p < 8; p++) begin
      write_count(phase_counts[p]);
      idle_pct = (p == 2) ? 0 : 36;
      n = (phase_counts[p] == 0) ? 10 : 68;
      for (int i = 0; i < n; i++) begin
        if (p == 0 && i == 34) drain();
        send(($urandom_range(99) < 55) ? ActAccess : ActReport, pick_item());
      end
    end

    drain();
    $display("Sent %0d accesses and %0d reports, item_count from 0 up to 127.",
             n_access, n_report);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- move_to_front_position_tracker_core.f -----
rtl/core/mtf_pkg.sv
rtl/core/mtf_cell.sv
rtl/core/mtf_gather.sv
rtl/core/move_to_front_position_tracker_core.sv
rtl/core/mtf_checker.sv
tb/mtf_position_checker.sv
tb/tb_move_to_front_position_tracker_core.sv
